FILE: design/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and constants shared by the framed packet receiver modules.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam logic [15:0] START_MARK = 16'h1BE4;
  localparam logic [15:0] END_MARK   = 16'hE41B;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 15;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_COMMAND = 3'd2,
    PH_DATA    = 3'd3,
    PH_CHECK   = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA      = 3'd0,
    KIND_ACK       = 3'd1,
    KIND_START_ERR = 3'd2,
    KIND_SUM_ERR   = 3'd3,
    KIND_END_ERR   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   value;
    logic [INDEX_W-1:0]  index;
  } result_t;

endpackage

FILE: design/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Receives two-byte messages, checks the packet frame and byte sum, and
// streams data words, ACK and NAK results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with in_low_byte and in_high_byte; one
//   message is one item, taken whenever in_valid is high and in_stall is low.
//   Result channel: out_valid / out_stall with out_result_kind, out_word_value
//   and out_word_index. Data words, ACK, start, checksum and end errors each
//   give one result item; marker, length, command and a good checksum give
//   none.
//   Each result is registered into the output stage, or into the skid stage
//   if the held result is stalled. One item is taken per cycle while in_stall
//   is low, set by the single frame state register and its 16-bit sum adder.
//   Reset (rst_n low, synchronous) empties the result stages and returns the
//   receiver to hunting for the start marker.
//   When the receiver stalls, the held result stays on the outputs and one
//   further result is caught in a skid stage; in_stall rises only while that
//   skid stage is full.
// ----------------------------------------------------------------------------
module framed_packet_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_low_byte,
  input  logic [7:0]                    in_high_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fpr_pkg::KIND_W-1:0]    out_result_kind,
  output logic [fpr_pkg::WORD_W-1:0]    out_word_value,
  output logic [fpr_pkg::INDEX_W-1:0]   out_word_index
);

  logic              item_en;
  logic              res_valid;
  fpr_pkg::result_t  res;

  logic              out_valid_r, out_valid_nxt;
  fpr_pkg::result_t  out_data_r, out_data_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  fpr_pkg::result_t  skid_data_r, skid_data_nxt;

  assign in_stall = skid_valid_r;
  assign item_en  = in_valid && !skid_valid_r;

  fpr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_en   (item_en),
    .low_byte  (in_low_byte),
    .high_byte (in_high_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      if (out_valid_r && out_stall) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_data_r.kind;
  assign out_word_value  = out_data_r.value;
  assign out_word_index  = out_data_r.index;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output stage empty");

  a_no_result_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_valid)
    else $error("result produced while skid stage full");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.kind <= fpr_pkg::KIND_END_ERR)
    else $error("illegal result kind on output");
`endif

endmodule

FILE: design/fpr_parser.sv
// ----------------------------------------------------------------------------
// fpr_parser
// Frame state machine: builds each word, tracks length and byte sum, and
// produces at most one result per accepted item.
// ----------------------------------------------------------------------------
module fpr_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_en,
  input  logic [7:0]                    low_byte,
  input  logic [7:0]                    high_byte,
  output logic                          res_valid,
  output fpr_pkg::result_t              res
);

  fpr_pkg::phase_t                  phase_r, phase_nxt;
  logic [fpr_pkg::INDEX_W-1:0]      words_left_r, words_left_nxt;
  logic [fpr_pkg::INDEX_W-1:0]      next_index_r, next_index_nxt;
  logic [fpr_pkg::WORD_W-1:0]       running_sum_r, running_sum_nxt;
  logic [fpr_pkg::WORD_W-1:0]       held_command_r, held_command_nxt;

  logic [fpr_pkg::WORD_W-1:0]       word;
  logic [fpr_pkg::WORD_W-1:0]       sum_add;

  assign word    = {high_byte, low_byte};
  assign sum_add = running_sum_r + {7'd0, ({1'b0, low_byte} + {1'b0, high_byte})};

  always_comb begin
    phase_nxt        = phase_r;
    words_left_nxt   = words_left_r;
    next_index_nxt   = next_index_r;
    running_sum_nxt  = running_sum_r;
    held_command_nxt = held_command_r;
    if (item_en) begin
      case (phase_r)
        fpr_pkg::PH_LENGTH: begin
          words_left_nxt  = word[15:1];
          running_sum_nxt = '0;
          phase_nxt       = fpr_pkg::PH_COMMAND;
        end
        fpr_pkg::PH_COMMAND: begin
          held_command_nxt = word;
          running_sum_nxt  = sum_add;
          next_index_nxt   = '0;
          phase_nxt        = (words_left_r != '0) ? fpr_pkg::PH_DATA : fpr_pkg::PH_CHECK;
        end
        fpr_pkg::PH_DATA: begin
          running_sum_nxt = sum_add;
          next_index_nxt  = next_index_r + 1'b1;
          words_left_nxt  = words_left_r - 1'b1;
          if (words_left_r == {{(fpr_pkg::INDEX_W-1){1'b0}}, 1'b1}) begin
            phase_nxt = fpr_pkg::PH_CHECK;
          end
        end
        fpr_pkg::PH_CHECK: begin
          phase_nxt = (word != running_sum_r) ? fpr_pkg::PH_HUNT : fpr_pkg::PH_END;
        end
        fpr_pkg::PH_END: begin
          phase_nxt = fpr_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = (word == fpr_pkg::START_MARK) ? fpr_pkg::PH_LENGTH : fpr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res.kind  = fpr_pkg::KIND_DATA;
    res.value = '0;
    res.index = '0;
    case (phase_r)
      fpr_pkg::PH_LENGTH, fpr_pkg::PH_COMMAND: begin
        res_valid = 1'b0;
      end
      fpr_pkg::PH_DATA: begin
        res_valid = item_en;
        res.kind  = fpr_pkg::KIND_DATA;
        res.value = word;
        res.index = next_index_r;
      end
      fpr_pkg::PH_CHECK: begin
        res_valid = item_en && (word != running_sum_r);
        res.kind  = fpr_pkg::KIND_SUM_ERR;
      end
      fpr_pkg::PH_END: begin
        res_valid = item_en;
        if (word == fpr_pkg::END_MARK) begin
          res.kind  = fpr_pkg::KIND_ACK;
          res.value = held_command_r;
        end else begin
          res.kind  = fpr_pkg::KIND_END_ERR;
        end
      end
      default: begin
        res_valid = item_en && (word != fpr_pkg::START_MARK);
        res.kind  = fpr_pkg::KIND_START_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= fpr_pkg::PH_HUNT;
      words_left_r   <= '0;
      next_index_r   <= '0;
      running_sum_r  <= '0;
      held_command_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      words_left_r   <= words_left_nxt;
      next_index_r   <= next_index_nxt;
      running_sum_r  <= running_sum_nxt;
      held_command_r <= held_command_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_data_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == fpr_pkg::PH_DATA |-> words_left_r != '0)
    else $error("data phase with no words left");

  a_length_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && phase_r == fpr_pkg::PH_LENGTH |=> running_sum_r == '0)
    else $error("byte sum not cleared after length word");
`endif

endmodule

FILE: verif/tb_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver
// Self-checking bench for the framed packet receiver. Sends start markers,
// length, command, data, checksum and end words, both well-formed frames and
// broken ones, mixed with stray words. A frame tracker in the bench predicts
// each data word, ACK and NAK, and every result item is compared field by
// field with the oldest prediction. The input idles and the result channel
// stalls at random, and one long receiver hold-off forces the block to stall
// its input.
module tb_framed_packet_receiver;

  import fpr_pkg::*;

  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_SUM,
    FAULT_END,
    FAULT_CUT
  } frame_fault_t;

  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned HOLD_CYCLES  = 64;

  class frame_scoreboard;
    phase_t                 phase;
    logic [INDEX_W-1:0]     words_left;
    logic [INDEX_W-1:0]     next_index;
    logic [WORD_W-1:0]      byte_total;
    logic [WORD_W-1:0]      held_command;
    result_t                pending_results[$];
    int unsigned            error_count;
    int unsigned            data_seen;
    int unsigned            ack_seen;
    int unsigned            start_err_seen;
    int unsigned            sum_err_seen;
    int unsigned            end_err_seen;

    function new();
      phase        = PH_HUNT;
      words_left   = '0;
      next_index   = '0;
      byte_total   = '0;
      held_command = '0;
      error_count  = 0;
      data_seen    = 0;
      ack_seen     = 0;
      start_err_seen = 0;
      sum_err_seen = 0;
      end_err_seen = 0;
    endfunction

    function void add_result(kind_t kind, logic [WORD_W-1:0] value,
                             logic [INDEX_W-1:0] index);
      result_t r;
      r.kind  = kind;
      r.value = value;
      r.index = index;
      pending_results.push_back(r);
    endfunction

    function void note_message(logic [7:0] lo, logic [7:0] hi);
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] byte_sum;
      word     = {hi, lo};
      byte_sum = 16'(lo) + 16'(hi);
      case (phase)
        PH_LENGTH: begin
          words_left = word[15:1];
          byte_total = '0;
          phase      = PH_COMMAND;
        end
        PH_COMMAND: begin
          held_command = word;
          byte_total   = byte_total + byte_sum;
          next_index   = '0;
          phase        = (words_left != 0) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          add_result(KIND_DATA, word, next_index);
          byte_total = byte_total + byte_sum;
          next_index = next_index + 1'b1;
          words_left = words_left - 1'b1;
          if (words_left == 0) phase = PH_CHECK;
        end
        PH_CHECK: begin
          if (word != byte_total) begin
            phase = PH_HUNT;
            add_result(KIND_SUM_ERR, '0, '0);
          end else begin
            phase = PH_END;
          end
        end
        PH_END: begin
          phase = PH_HUNT;
          if (word != END_MARK) add_result(KIND_END_ERR, '0, '0);
          else add_result(KIND_ACK, held_command, '0);
        end
        default: begin
          if (word != START_MARK) begin
            phase = PH_HUNT;
            add_result(KIND_START_ERR, '0, '0);
          end else begin
            phase = PH_LENGTH;
          end
        end
      endcase
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value,
                               logic [INDEX_W-1:0] index);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d value %h index %0d", kind, value, index);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (kind !== exp_r.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_r.kind, kind);
          error_count++;
        end
        if (value !== exp_r.value) begin
          $error("word_value: expected %h, got %h", exp_r.value, value);
          error_count++;
        end
        if (index !== exp_r.index) begin
          $error("word_index: expected %0d, got %0d", exp_r.index, index);
          error_count++;
        end
        case (exp_r.kind)
          KIND_DATA:      data_seen++;
          KIND_ACK:       ack_seen++;
          KIND_START_ERR: start_err_seen++;
          KIND_SUM_ERR:   sum_err_seen++;
          default:        end_err_seen++;
        endcase
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_low_byte = '0;
  logic [7:0]           in_high_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_result_kind;
  logic [WORD_W-1:0]    out_word_value;
  logic [INDEX_W-1:0]   out_word_index;

  frame_scoreboard      frame_check = new();
  int unsigned          items_sent = 0;
  int unsigned          frames_sent = 0;
  bit                   no_gaps = 1'b0;
  bit                   flood = 1'b0;
  bit                   hold_done = 1'b0;

  framed_packet_receiver u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_low_byte     (in_low_byte),
    .in_high_byte    (in_high_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_word_value  (out_word_value),
    .out_word_index  (out_word_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      frame_check.check_result(out_result_kind, out_word_value, out_word_index);
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 19);
    if (no_gaps || flood || r < 13) gap = 0;
    else if (r < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 25);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_low_byte  <= w[7:0];
    in_high_byte <= w[15:8];
    do @(posedge clk); while (in_stall);
    frame_check.note_message(w[7:0], w[15:8]);
    items_sent++;
  endtask

  task automatic send_frame(input logic [WORD_W-1:0] cmd, input logic [WORD_W-1:0] len,
                            input frame_fault_t fault, input bit extreme_fill);
    logic [WORD_W-1:0] total;
    logic [WORD_W-1:0] w;
    int unsigned       n_words;
    int unsigned       stop_at;
    n_words = len >> 1;
    total   = 16'(cmd[7:0]) + 16'(cmd[15:8]);
    stop_at = (fault == FAULT_CUT) ? $urandom_range(0, n_words) : n_words;
    frames_sent++;
    send_word(START_MARK);
    send_word(len);
    send_word(cmd);
    for (int i = 0; i < stop_at; i++) begin
      if (extreme_fill) w = i[0] ? 16'hFFFF : 16'h0000;
      else w = 16'($urandom);
      total = total + 16'(w[7:0]) + 16'(w[15:8]);
      send_word(w);
    end
    if (fault == FAULT_CUT) return;
    if (fault == FAULT_SUM) total = total + 16'($urandom_range(1, 65535));
    send_word(total);
    if (fault == FAULT_SUM) return;
    if (fault == FAULT_END) begin
      do w = 16'($urandom); while (w == END_MARK);
    end else begin
      w = END_MARK;
    end
    send_word(w);
  endtask

  initial begin : result_sink
    int unsigned r;
    int unsigned len;
    forever begin
      if (flood && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 10) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 16);
        end else if (r < 17) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(8, 30);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned       r;
    int unsigned       random_start;
    frame_fault_t      fault;
    logic [WORD_W-1:0] len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(16'h0000);
    send_word(16'hFFFF);
    send_frame(16'hFFFF, 16'h0000, FAULT_NONE, 1'b0);
    send_frame(16'h0000, 16'h0001, FAULT_END, 1'b0);
    send_frame(16'hA55A, 16'h0004, FAULT_SUM, 1'b1);
    send_frame(16'h5AA5, 16'h0005, FAULT_NONE, 1'b1);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (!hold_done && items_sent - random_start > RANDOM_ITEMS / 2) begin
        flood = 1'b1;
        while (!hold_done) send_frame(16'($urandom), 16'd32, FAULT_NONE, 1'b0);
        flood = 1'b0;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(16'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) fault = FAULT_NONE;
        else if (r < 80) fault = FAULT_SUM;
        else if (r < 90) fault = FAULT_END;
        else fault = FAULT_CUT;
        if ($urandom_range(0, 39) == 0) len = 16'($urandom_range(200, 600));
        else len = 16'($urandom_range(0, 24));
        send_frame(16'($urandom), len, fault, 1'b0);
      end
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    while (frame_check.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items in %0d frames plus stray words.", items_sent, frames_sent);
    $display("Checked %0d data words, %0d ACKs, %0d start, %0d checksum, %0d end errors.",
             frame_check.data_seen, frame_check.ack_seen, frame_check.start_err_seen,
             frame_check.sum_err_seen, frame_check.end_err_seen);
    if (frame_check.error_count == 0 && frame_check.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
